// ----- rtl/pt2d_pkg.sv -----
// Shared types, constants and the sine table builder for the 2-D point transform.
// Used by pt2d_sincos and point_transform_2d_core; depends on nothing else.
`timescale 1ns / 1ps

package pt2d_pkg;

    // Coordinate width is fixed by the word formats below.
    localparam int COORD_W       = 16;
    localparam int SCALE_W       = 9;
    localparam int ANGLE_W       = 9;
    localparam int MODE_W        = 2;
    localparam int TRIG_FRAC_DEF = 14;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DW        = (COORD_W > SCALE_W) ? COORD_W : SCALE_W;

    // Angle landmarks in degrees.
    localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(90);
    localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180);
    localparam logic [ANGLE_W-1:0] DEG_270 = ANGLE_W'(270);
    localparam logic [ANGLE_W-1:0] DEG_360 = ANGLE_W'(360);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y  = 3'd7;

    typedef enum logic [MODE_W-1:0] {
        MODE_SCALE     = 2'd0,
        MODE_TRANSLATE = 2'd1,
        MODE_ROTATE    = 2'd2
    } mode_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_in;
        logic signed [COORD_W-1:0] y_in;
    } pt2d_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_out;
        logic signed [COORD_W-1:0] y_out;
        logic                      saturated;
    } pt2d_out_t;

    // Working precision of the series evaluation, and pi in that format.
    localparam int                WORK_FRAC = 30;
    localparam longint unsigned   PI_WORK   = 64'd3373259426;

    // Divisors of the Taylor terms: (2n)(2n+1) for n = 1..12.
    localparam longint unsigned SERIES_DIV [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // sin(d degrees) for d in 0..90, rounded to frac fraction bits. Evaluated
    // only while building the constant table at elaboration.
    function automatic longint unsigned trig_entry(input int unsigned d,
                                                   input int unsigned frac);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        int unsigned     sh;
        x    = (longint'(d) * PI_WORK) / 180;
        x2   = (x * x) >> WORK_FRAC;
        term = x;
        sum  = x;
        for (int unsigned n = 1; n <= 12; n++) begin
            term = ((term * x2) >> WORK_FRAC) / SERIES_DIV[n];
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        sh = WORK_FRAC - frac;
        return (sum + (64'd1 << (sh - 1))) >> sh;
    endfunction

endpackage

// ----- rtl/pt2d_sincos.sv -----
// Sine and cosine of a whole-degree angle from a 91-entry quarter-wave table.
// Depends on pt2d_pkg for the table builder and angle constants.
`timescale 1ns / 1ps

module pt2d_sincos import pt2d_pkg::*; #(
    parameter int FRAC = TRIG_FRAC_DEF
) (
    input  logic [ANGLE_W-1:0]        angle,
    output logic signed [FRAC+1:0]    sin_q,
    output logic signed [FRAC+1:0]    cos_q
);

    localparam int B = FRAC + 2;

    typedef logic [FRAC:0] mag_t;
    typedef mag_t tab_t [0:90];

    function automatic tab_t build_tab();
        tab_t t;
        for (int unsigned d = 0; d <= 90; d++) begin
            t[d] = mag_t'(trig_entry(d, FRAC));
        end
        return t;
    endfunction

    localparam tab_t SIN_TAB = build_tab();

    // Quadrant fold: the table covers 0..90 degrees, the rest by symmetry.
    function automatic logic signed [B-1:0] fold(input logic [ANGLE_W-1:0] d);
        logic [6:0]          idx;
        logic                neg;
        logic signed [B-1:0] mag;
        neg = 1'b0;
        if (d <= DEG_90) begin
            idx = d[6:0];
        end else if (d <= DEG_180) begin
            idx = 7'(DEG_180 - d);
        end else if (d <= DEG_270) begin
            idx = 7'(d - DEG_180);
            neg = 1'b1;
        end else begin
            idx = 7'(DEG_360 - d);
            neg = 1'b1;
        end
        mag = signed'({1'b0, SIN_TAB[idx]});
        return neg ? -mag : mag;
    endfunction

    logic [ANGLE_W-1:0] ang_wrap;
    logic [ANGLE_W:0]   cos_sum;
    logic [ANGLE_W-1:0] cos_ang;

    // Angles 360..511 wrap once; the cosine angle is the sine angle plus 90.
    assign ang_wrap = (angle >= DEG_360) ? (angle - DEG_360) : angle;
    assign cos_sum  = {1'b0, ang_wrap} + {1'b0, DEG_90};
    assign cos_ang  = (cos_sum >= {1'b0, DEG_360}) ? ANGLE_W'(cos_sum - {1'b0, DEG_360})
                                                   : cos_sum[ANGLE_W-1:0];

    assign sin_q = fold(ang_wrap);
    assign cos_q = fold(cos_ang);

endmodule

// ----- rtl/point_transform_2d_core.sv -----
// A word passes operand, product, sum, shift and output registers to reach m_data.
// Throughput: one word per cycle unless m_ready stalls; each stage holds a word while the next is full,
// so the input keeps accepting as long as any bubble remains in the five stages.
// Reset (aresetn low, synchronous) empties the pipeline and loads mode 0 (scale),
// scale factors 1, offsets, angle and pivot 0.
`timescale 1ns / 1ps

module point_transform_2d_core import pt2d_pkg::*; #(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pt2d_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pt2d_out_t            m_data
);

    localparam int W  = COORD_W;
    localparam int F  = TRIG_FRAC_BITS;
    localparam int B  = F + 2;     // signed trig / factor operand
    localparam int AW = W + 1;     // differences and sums of two coordinates
    localparam int PW = AW + B;    // products
    localparam int SW = PW + 1;    // product sums
    localparam int RW = SW + 1;    // after the pivot is added back

    // Configuration registers.
    logic [MODE_W-1:0]         mode_reg;
    logic signed [SCALE_W-1:0] scale_x_reg, scale_y_reg;
    logic signed [W-1:0]       offset_x_reg, offset_y_reg;
    logic [ANGLE_W-1:0]        turn_reg;
    logic signed [W-1:0]       pivot_x_reg, pivot_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_SCALE;
            scale_x_reg  <= SCALE_W'(1);
            scale_y_reg  <= SCALE_W'(1);
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            turn_reg     <= '0;
            pivot_x_reg  <= '0;
            pivot_y_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_wdata[MODE_W-1:0];
                REG_SCALE_X:  scale_x_reg  <= cfg_wdata[SCALE_W-1:0];
                REG_SCALE_Y:  scale_y_reg  <= cfg_wdata[SCALE_W-1:0];
                REG_OFFSET_X: offset_x_reg <= cfg_wdata[W-1:0];
                REG_OFFSET_Y: offset_y_reg <= cfg_wdata[W-1:0];
                REG_TURN:     turn_reg     <= cfg_wdata[ANGLE_W-1:0];
                REG_PIVOT_X:  pivot_x_reg  <= cfg_wdata[W-1:0];
                REG_PIVOT_Y:  pivot_y_reg  <= cfg_wdata[W-1:0];
                default: ;
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or its word moves on.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5     = !v5_reg || m_ready;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: operand selection. Every mode is mapped onto the products
    // a0*k0, a1*k1, a0*k1, a1*k0; only rotation uses the cross terms.
    logic signed [B-1:0]  sin_q, cos_q;
    logic signed [AW-1:0] xe, ye;
    logic signed [AW-1:0] a0_next, a1_next;
    logic signed [B-1:0]  k0_next, k1_next;
    logic                 rot1_next;

    pt2d_sincos #(
        .FRAC (F)
    ) u_sincos (
        .angle (turn_reg),
        .sin_q (sin_q),
        .cos_q (cos_q)
    );

    assign xe = AW'(s_data.x_in);
    assign ye = AW'(s_data.y_in);

    always_comb begin
        rot1_next = 1'b0;
        a0_next   = xe;
        a1_next   = ye;
        k0_next   = B'(1);
        k1_next   = B'(1);
        case (mode_reg)
            MODE_SCALE: begin
                k0_next = B'(scale_x_reg);
                k1_next = B'(scale_y_reg);
            end
            MODE_TRANSLATE: begin
                a0_next = xe + AW'(offset_x_reg);
                a1_next = ye + AW'(offset_y_reg);
            end
            MODE_ROTATE: begin
                rot1_next = 1'b1;
                a0_next   = xe - AW'(pivot_x_reg);
                a1_next   = ye - AW'(pivot_y_reg);
                k0_next   = cos_q;
                k1_next   = sin_q;
            end
            default: ;  // the word passes unchanged
        endcase
    end

    logic                 rot1_reg, rot2_reg, rot3_reg, rot4_reg;
    logic signed [AW-1:0] a0_reg, a1_reg;
    logic signed [B-1:0]  k0_reg, k1_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [SW-1:0] sx_reg, sy_reg;
    logic signed [SW-1:0] tx_reg, ty_reg;
    pt2d_out_t            out_reg;

    // Stage 3 and 4 combinational terms.
    logic signed [SW-1:0] sx_next, sy_next;
    logic signed [SW-1:0] bx, by, ux, uy, tx_next, ty_next;
    // Stage 5 terms.
    logic signed [RW-1:0] rx, ry;
    logic                 ovx, ovy;
    pt2d_out_t            out_next;

    assign sx_next = rot2_reg ? (SW'(p0_reg) - SW'(p1_reg)) : SW'(p0_reg);
    assign sy_next = rot2_reg ? (SW'(p2_reg) + SW'(p3_reg)) : SW'(p1_reg);

    // Division by 2^F truncated toward zero: negative sums get a bias first.
    assign bx      = {{(SW-F){1'b0}}, {F{sx_reg[SW-1]}}};
    assign by      = {{(SW-F){1'b0}}, {F{sy_reg[SW-1]}}};
    assign ux      = sx_reg + bx;
    assign uy      = sy_reg + by;
    assign tx_next = rot3_reg ? (ux >>> F) : sx_reg;
    assign ty_next = rot3_reg ? (uy >>> F) : sy_reg;

    assign rx = RW'(tx_reg) + (rot4_reg ? RW'(pivot_x_reg) : RW'(0));
    assign ry = RW'(ty_reg) + (rot4_reg ? RW'(pivot_y_reg) : RW'(0));

    // Out of range when the bits above the coordinate differ from its sign.
    assign ovx = (rx[RW-1:W-1] != {(RW-W+1){rx[RW-1]}});
    assign ovy = (ry[RW-1:W-1] != {(RW-W+1){ry[RW-1]}});

    always_comb begin
        out_next.x_out     = rx[W-1:0];
        out_next.y_out     = ry[W-1:0];
        out_next.saturated = ovx || ovy;
        if (ovx) begin
            out_next.x_out = {rx[RW-1], {(W-1){!rx[RW-1]}}};
        end
        if (ovy) begin
            out_next.y_out = {ry[RW-1], {(W-1){!ry[RW-1]}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            rot1_reg <= rot1_next;
            a0_reg   <= a0_next;
            a1_reg   <= a1_next;
            k0_reg   <= k0_next;
            k1_reg   <= k1_next;
        end
        if (en2) begin
            rot2_reg <= rot1_reg;
            p0_reg   <= PW'(a0_reg) * PW'(k0_reg);
            p1_reg   <= PW'(a1_reg) * PW'(k1_reg);
            p2_reg   <= PW'(a0_reg) * PW'(k1_reg);
            p3_reg   <= PW'(a1_reg) * PW'(k0_reg);
        end
        if (en3) begin
            rot3_reg <= rot2_reg;
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
        end
        if (en4) begin
            rot4_reg <= rot3_reg;
            tx_reg   <= tx_next;
            ty_reg   <= ty_next;
        end
        if (en5) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    // With the output stage empty, no stage can be blocked.
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v5_reg |-> s_ready)
        else $error("input not ready although the output stage is empty");

    // A result only appears after a word has reached stage four.
    a_result_from_stage4: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v5_reg) |-> $past(v4_reg))
        else $error("result appeared without a word in stage four");

    // A word held in stage one while stage two is blocked stays, with a0 and k0 unchanged.
    a_stage1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !en2 |=> v1_reg && $stable(a0_reg) && $stable(k0_reg))
        else $error("stalled stage one word was lost or changed");

endmodule
